// File: rtl/core/ccdc_pkg.sv
package ccdc_pkg;

	localparam int TEMP_W    = 16;
	localparam int DUTY_W    = 7;
	localparam int RAW_W     = 8;
	localparam int CFG_W     = 64;
	localparam int CFG_IDX_W = 3;
	localparam int PT_W      = 16;
	localparam int LAST_PT   = 3;

	localparam logic [RAW_W-1:0] DUTY_FULL = 8'd100;

	typedef logic [DUTY_W-1:0] duty_t;
	typedef logic [RAW_W-1:0]  raw_duty_t;

	typedef enum logic [2:0] {
		MODE_AUTO        = 3'd0,
		MODE_SILENT      = 3'd1,
		MODE_QUIET       = 3'd2,
		MODE_BALANCED    = 3'd3,
		MODE_PERFORMANCE = 3'd4,
		MODE_DISABLED    = 3'd5
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MODE        = 3'd0,
		REG_PUMP_TEMPS  = 3'd1,
		REG_PUMP_DUTIES = 3'd2,
		REG_FAN_TEMPS   = 3'd3,
		REG_FAN_DUTIES  = 3'd4,
		REG_PRESETS     = 3'd5,
		REG_LIMITS      = 3'd6
	} reg_idx_t;

	localparam logic [63:0] RST_PUMP_TEMPS  = 64'd163257891708600820;
	localparam logic [31:0] RST_PUMP_DUTIES = 32'd1682649630;
	localparam logic [63:0] RST_FAN_TEMPS   = 64'd163257891708600820;
	localparam logic [31:0] RST_FAN_DUTIES  = 32'd1682648350;
	localparam logic [63:0] RST_PRESETS     = 64'd0;
	localparam logic [23:0] RST_LIMITS      = 24'd6558740;

	// breakpoints past the fourth read the fourth
	function automatic logic [PT_W-1:0] point_temp(input logic [63:0] temps, input int idx);
		int k;
		k = (idx > LAST_PT) ? LAST_PT : idx;
		return temps[PT_W*k +: PT_W];
	endfunction

	function automatic raw_duty_t point_duty(input logic [31:0] duties, input int idx);
		int k;
		k = (idx > LAST_PT) ? LAST_PT : idx;
		return duties[RAW_W*k +: RAW_W];
	endfunction

endpackage

// File: rtl/core/ccdc_if.sv
interface ccdc_sample_if;
	logic                                valid;
	logic                                ready;
	logic signed [ccdc_pkg::TEMP_W-1:0]  temp_tenths;
	logic                                temp_ok;

	modport source (output valid, output temp_tenths, output temp_ok, input ready);
	modport sink   (input valid, input temp_tenths, input temp_ok, output ready);
endinterface

interface ccdc_result_if;
	logic                  valid;
	logic                  ready;
	ccdc_pkg::duty_t       pump_pct;
	ccdc_pkg::duty_t       fan_pct;
	logic                  command_sent;

	modport source (output valid, output pump_pct, output fan_pct, output command_sent,
		input ready);
	modport sink   (input valid, input pump_pct, input fan_pct, input command_sent,
		output ready);
endinterface

// File: rtl/core/ccdc_curve_eval.sv
module ccdc_curve_eval #(
	parameter int CURVE_POINTS = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [ccdc_pkg::PT_W-1:0]     temp,
	input  logic [63:0]                   temps,
	input  logic [31:0]                   duties,
	output logic                          done,
	output ccdc_pkg::raw_duty_t           duty
);

	typedef enum logic [4:0] {
		EV_IDLE = 5'b00001,
		EV_MUL1 = 5'b00010,
		EV_MUL2 = 5'b00100,
		EV_DIV  = 5'b01000,
		EV_DONE = 5'b10000
	} ev_state_t;

	ev_state_t state_q;

	logic [ccdc_pkg::PT_W-1:0] p_first, p_last, seg_lo, seg_hi;
	ccdc_pkg::raw_duty_t       seg_dlo, seg_dhi, direct_duty;
	logic                      direct;

	logic [15:0]               span_q, diff_q;
	ccdc_pkg::raw_duty_t       dlo_q, dhi_q, q_q;
	logic signed [16:0]        mul_a;
	logic signed [9:0]         mul_b;
	logic signed [26:0]        prod, acc_q, num;
	logic [24:0]               rem_q, div_sh;
	logic [16:0]               den_q;
	logic [2:0]                k_q;
	logic                      div_ge;

	// segment select: first breakpoint at or above the sample
	always_comb begin
		p_first     = ccdc_pkg::point_temp(temps, 0);
		p_last      = ccdc_pkg::point_temp(temps, CURVE_POINTS - 1);
		seg_lo      = '0;
		seg_hi      = '0;
		seg_dlo     = '0;
		seg_dhi     = '0;
		direct      = 1'b0;
		direct_duty = '0;
		for (int i = CURVE_POINTS - 1; i >= 1; i--) begin
			if (temp <= ccdc_pkg::point_temp(temps, i)) begin
				seg_hi  = ccdc_pkg::point_temp(temps, i);
				seg_lo  = ccdc_pkg::point_temp(temps, i - 1);
				seg_dhi = ccdc_pkg::point_duty(duties, i);
				seg_dlo = ccdc_pkg::point_duty(duties, i - 1);
			end
		end
		if (temp <= p_first) begin
			direct      = 1'b1;
			direct_duty = ccdc_pkg::point_duty(duties, 0);
		end else if (temp >= p_last) begin
			direct      = 1'b1;
			direct_duty = ccdc_pkg::point_duty(duties, CURVE_POINTS - 1);
		end else if (seg_hi <= seg_lo) begin
			direct      = 1'b1;
			direct_duty = seg_dlo;
		end
	end

	// shared multiplier: span*(2*dlo+1), then (t-lo)*(dhi-dlo)
	always_comb begin
		if (state_q == EV_MUL1) begin
			mul_a = $signed({1'b0, span_q});
			mul_b = $signed({1'b0, dlo_q, 1'b1});
		end else begin
			mul_a = $signed({1'b0, diff_q});
			mul_b = $signed({2'b00, dhi_q}) - $signed({2'b00, dlo_q});
		end
	end

	assign prod   = mul_a * mul_b;
	assign num    = acc_q + (prod <<< 1);
	assign div_sh = {8'd0, den_q} << k_q;
	assign div_ge = rem_q >= div_sh;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EV_IDLE;
			k_q     <= '0;
		end else begin
			case (state_q)
				EV_IDLE: begin
					if (start) state_q <= direct ? EV_DONE : EV_MUL1;
				end
				EV_MUL1: state_q <= EV_MUL2;
				EV_MUL2: begin
					state_q <= EV_DIV;
					k_q     <= 3'd7;
				end
				EV_DIV: begin
					if (k_q == 3'd0) state_q <= EV_DONE;
					else k_q <= k_q - 3'd1;
				end
				EV_DONE: state_q <= EV_IDLE;
				default: state_q <= EV_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EV_IDLE: begin
				span_q <= seg_hi - seg_lo;
				diff_q <= temp - seg_lo;
				dlo_q  <= seg_dlo;
				dhi_q  <= seg_dhi;
				q_q    <= direct_duty;
			end
			EV_MUL1: acc_q <= prod;
			EV_MUL2: begin
				// numerator stays positive and below 2^25 inside a segment
				rem_q <= num[24:0];
				den_q <= {span_q, 1'b0};
				q_q   <= '0;
			end
			EV_DIV: begin
				if (div_ge) begin
					rem_q     <= rem_q - div_sh;
					q_q[k_q]  <= 1'b1;
				end
			end
			default: ;
		endcase
	end

	assign done = (state_q == EV_DONE);
	assign duty = q_q;

endmodule

// File: rtl/core/cooling_curve_duty_controller_unit.sv
// Pump/fan duty from liquid temperature via two piecewise-linear curves.
// Auto mode with a valid non-negative sample runs the pump curve, then the fan curve, each
// on one shared multiply/divide unit with an 8-step restoring divide (skipped off the curve
// ends or on a flat segment); other cases go straight to the output register.
// The next sample is taken in the cycle after the result loads, so samples are handled
// one at a time; a result still waiting in the output register stalls the following one
// at load. Reset (arst_n low, async): registers to defaults, held duties to zero.
module cooling_curve_duty_controller_unit #(
	parameter int CURVE_POINTS = 4
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ccdc_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [ccdc_pkg::CFG_W-1:0]      cfg_wdata,
	ccdc_sample_if.sink                     sample,
	ccdc_result_if.source                   result
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_PUMP = 4'b0010,
		ST_FAN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [2:0]  mode_q;
	logic [63:0] pump_temps_q, fan_temps_q, presets_q;
	logic [31:0] pump_duties_q, fan_duties_q;
	logic [23:0] limits_q;

	// held duties: last command sent
	ccdc_pkg::duty_t held_pump_q, held_fan_q;

	// per-sample working registers
	logic [ccdc_pkg::PT_W-1:0]  temp_q;
	ccdc_pkg::raw_duty_t        pump_raw_q, fan_raw_q;
	logic                       cmd_q;
	logic                       start_q;

	// output register
	logic                       out_valid_q;
	ccdc_pkg::duty_t            out_pump_q, out_fan_q;
	logic                       out_cmd_q;

	logic                       in_fire, go_curve, out_load;
	ccdc_pkg::raw_duty_t        pre_pump, pre_fan;
	ccdc_pkg::raw_duty_t        pump_floor, fan_floor, pump_max, pump_lo, fan_lo;
	ccdc_pkg::duty_t            pump_clamped, fan_clamped;

	logic [63:0]                ev_temps;
	logic [31:0]                ev_duties;
	logic                       ev_done;
	ccdc_pkg::raw_duty_t        ev_duty;

	assign sample.ready = (state_q == ST_IDLE);
	assign in_fire      = sample.valid && sample.ready;

	// ---------------------------------------------------------------
	// Config writes; out-of-range index is dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= ccdc_pkg::MODE_AUTO;
			pump_temps_q  <= ccdc_pkg::RST_PUMP_TEMPS;
			pump_duties_q <= ccdc_pkg::RST_PUMP_DUTIES;
			fan_temps_q   <= ccdc_pkg::RST_FAN_TEMPS;
			fan_duties_q  <= ccdc_pkg::RST_FAN_DUTIES;
			presets_q     <= ccdc_pkg::RST_PRESETS;
			limits_q      <= ccdc_pkg::RST_LIMITS;
		end else if (cfg_we) begin
			case (ccdc_pkg::reg_idx_t'(cfg_idx))
				ccdc_pkg::REG_MODE:        mode_q        <= cfg_wdata[2:0];
				ccdc_pkg::REG_PUMP_TEMPS:  pump_temps_q  <= cfg_wdata;
				ccdc_pkg::REG_PUMP_DUTIES: pump_duties_q <= cfg_wdata[31:0];
				ccdc_pkg::REG_FAN_TEMPS:   fan_temps_q   <= cfg_wdata;
				ccdc_pkg::REG_FAN_DUTIES:  fan_duties_q  <= cfg_wdata[31:0];
				ccdc_pkg::REG_PRESETS:     presets_q     <= cfg_wdata;
				ccdc_pkg::REG_LIMITS:      limits_q      <= cfg_wdata[23:0];
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Sample decode: preset modes pick byte pairs, auto needs a valid,
	// non-negative sample for the curves, otherwise held duties.
	// Codes 6 and 7 behave as auto.
	// ---------------------------------------------------------------
	always_comb begin
		pre_pump = {1'b0, held_pump_q};
		pre_fan  = {1'b0, held_fan_q};
		go_curve = 1'b0;
		case (ccdc_pkg::mode_t'(mode_q))
			ccdc_pkg::MODE_SILENT: begin
				pre_pump = presets_q[7:0];
				pre_fan  = presets_q[15:8];
			end
			ccdc_pkg::MODE_QUIET: begin
				pre_pump = presets_q[23:16];
				pre_fan  = presets_q[31:24];
			end
			ccdc_pkg::MODE_BALANCED: begin
				pre_pump = presets_q[39:32];
				pre_fan  = presets_q[47:40];
			end
			ccdc_pkg::MODE_PERFORMANCE: begin
				pre_pump = presets_q[55:48];
				pre_fan  = presets_q[63:56];
			end
			ccdc_pkg::MODE_DISABLED: ;
			default: go_curve = sample.temp_ok && !sample.temp_tenths[ccdc_pkg::TEMP_W-1];
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: pump curve, then fan curve, then hand to output reg
	// ---------------------------------------------------------------
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			start_q     <= 1'b0;
			out_valid_q <= 1'b0;
			held_pump_q <= '0;
			held_fan_q  <= '0;
		end else begin
			start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (go_curve) begin
							state_q <= ST_PUMP;
							start_q <= 1'b1;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_PUMP: begin
					if (ev_done) begin
						state_q <= ST_FAN;
						start_q <= 1'b1;
					end
				end
				ST_FAN: begin
					if (ev_done) state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (out_load) out_valid_q <= 1'b1;
			else if (result.ready) out_valid_q <= 1'b0;

			// disabled mode leaves the held duties alone
			if (out_load && cmd_q) begin
				held_pump_q <= pump_clamped;
				held_fan_q  <= fan_clamped;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			temp_q     <= sample.temp_tenths;
			pump_raw_q <= pre_pump;
			fan_raw_q  <= pre_fan;
			cmd_q      <= (mode_q != ccdc_pkg::MODE_DISABLED);
		end
		if (ev_done && state_q == ST_PUMP) pump_raw_q <= ev_duty;
		if (ev_done && state_q == ST_FAN)  fan_raw_q  <= ev_duty;
		if (out_load) begin
			out_pump_q <= cmd_q ? pump_clamped : '0;
			out_fan_q  <= cmd_q ? fan_clamped : '0;
			out_cmd_q  <= cmd_q;
		end
	end

	// ---------------------------------------------------------------
	// Clamp: floor first, then maximum (a floor above max yields max)
	// ---------------------------------------------------------------
	always_comb begin
		pump_floor = limits_q[7:0];
		fan_floor  = limits_q[15:8];
		pump_max   = (limits_q[23:16] > ccdc_pkg::DUTY_FULL) ? ccdc_pkg::DUTY_FULL
			: limits_q[23:16];
		pump_lo    = (pump_raw_q < pump_floor) ? pump_floor : pump_raw_q;
		fan_lo     = (fan_raw_q < fan_floor) ? fan_floor : fan_raw_q;
		pump_clamped = (pump_lo > pump_max) ? pump_max[ccdc_pkg::DUTY_W-1:0]
			: pump_lo[ccdc_pkg::DUTY_W-1:0];
		fan_clamped  = (fan_lo > ccdc_pkg::DUTY_FULL)
			? ccdc_pkg::DUTY_FULL[ccdc_pkg::DUTY_W-1:0] : fan_lo[ccdc_pkg::DUTY_W-1:0];
	end

	// ---------------------------------------------------------------
	// Shared curve evaluator; curve chosen by sequencer state
	// ---------------------------------------------------------------
	assign ev_temps  = (state_q == ST_FAN) ? fan_temps_q : pump_temps_q;
	assign ev_duties = (state_q == ST_FAN) ? fan_duties_q : pump_duties_q;

	ccdc_curve_eval #(
		.CURVE_POINTS (CURVE_POINTS)
	) u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.temp   (temp_q),
		.temps  (ev_temps),
		.duties (ev_duties),
		.done   (ev_done),
		.duty   (ev_duty)
	);

	assign result.valid        = out_valid_q;
	assign result.pump_pct     = out_pump_q;
	assign result.fan_pct      = out_fan_q;
	assign result.command_sent = out_cmd_q;

endmodule

// File: tb/cooling_curve_duty_controller_unit_test.sv
`timescale 1ns / 1ps

module cooling_curve_duty_controller_unit_test;

	localparam int CURVE_POINTS  = 4;
	localparam int RANDOM_ITEMS  = 1700;
	localparam int SETTLE_CYCLES = 40;      // longer than the curve latency
	localparam int CYCLE_LIMIT   = 1000000;
	localparam int REPORT_MAX    = 20;

	// codes outside the package enums
	localparam logic [2:0] REG_UNUSED   = 3'd7;
	localparam logic [2:0] MODE_SPARE_6 = 3'd6;
	localparam logic [2:0] MODE_SPARE_7 = 3'd7;

	typedef struct {
		logic signed [ccdc_pkg::TEMP_W-1:0] temp;
		logic                               ok;
	} sample_t;

	typedef struct {
		ccdc_pkg::duty_t pump;
		ccdc_pkg::duty_t fan;
		logic            sent;
	} duty_cmd_t;

	logic clk;
	logic arst_n;
	logic                           cfg_we;
	logic [ccdc_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [ccdc_pkg::CFG_W-1:0]     cfg_wdata;

	ccdc_sample_if smp ();
	ccdc_result_if res ();

	cooling_curve_duty_controller_unit #(
		.CURVE_POINTS(CURVE_POINTS)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_wdata(cfg_wdata),
		.sample   (smp),
		.result   (res)
	);

	// shadow of the register file and the held duties
	logic [2:0]  cur_mode;
	logic [63:0] pump_temps;
	logic [31:0] pump_duties;
	logic [63:0] fan_temps;
	logic [31:0] fan_duties;
	logic [63:0] presets;
	logic [23:0] limits;
	int          held_pump;
	int          held_fan;

	sample_t   pending_samples[$];
	duty_cmd_t expected_cmds[$];

	bit      steady;            // phase with no gaps and no stalls
	int      gap_left;
	int      stall_left;
	sample_t drv_sample;
	int      errors;
	int      cycles;
	int      checked;
	int      phases;
	int      n_curve, n_held, n_preset, n_off;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				expected_cmds.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// mostly no gap, some short, a few long
	function automatic int gap_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Duty from one curve; t is non-negative here.
	function automatic int curve_duty(logic [63:0] temps, logic [31:0] duties, int t);
		int     last;
		int     lo, hi;
		longint dlo, dhi, span, num;
		last = (CURVE_POINTS - 1 > 3) ? 3 : CURVE_POINTS - 1;
		lo = int'(temps[15:0]);
		if (t <= lo) return int'(duties[7:0]);
		hi = int'(temps[16*last +: 16]);
		if (t >= hi) return int'(duties[8*last +: 8]);
		for (int i = 1; i < CURVE_POINTS; i++) begin
			hi = int'(temps[16*((i > 3) ? 3 : i) +: 16]);
			if (t <= hi) begin
				lo  = int'(temps[16*((i - 1 > 3) ? 3 : i - 1) +: 16]);
				dlo = longint'(duties[8*((i - 1 > 3) ? 3 : i - 1) +: 8]);
				dhi = longint'(duties[8*((i > 3) ? 3 : i) +: 8]);
				// flat or inverted segment: lower duty
				if (hi <= lo) return int'(dlo);
				span = longint'(hi - lo);
				// doubled to keep the half-up rounding exact
				num = 2 * dlo * span + 2 * (longint'(t) - longint'(lo)) * (dhi - dlo) + span;
				if (num < 0) num = 0;
				return int'(num / (2 * span));
			end
		end
		return int'(duties[8*last +: 8]);
	endfunction

	// Expected command for one accepted sample; advances the held duties unless disabled.
	function automatic duty_cmd_t next_duty_command(logic signed [ccdc_pkg::TEMP_W-1:0] temp,
		logic ok);
		duty_cmd_t cmd;
		int        t, pump, fan, pf, ff, pmax, sh;
		t = int'(temp);
		if (cur_mode == ccdc_pkg::MODE_DISABLED) begin
			n_off++;
			cmd.pump = '0;
			cmd.fan  = '0;
			cmd.sent = 1'b0;
			return cmd;
		end
		case (cur_mode)
			ccdc_pkg::MODE_SILENT, ccdc_pkg::MODE_QUIET, ccdc_pkg::MODE_BALANCED,
			ccdc_pkg::MODE_PERFORMANCE: begin
				sh   = 16 * (int'(cur_mode) - 1);
				pump = int'(presets[sh +: 8]);
				fan  = int'(presets[sh + 8 +: 8]);
				n_preset++;
			end
			default: begin
				// auto, and the undefined codes 6/7
				if (ok && t >= 0) begin
					pump = curve_duty(pump_temps, pump_duties, t);
					fan  = curve_duty(fan_temps, fan_duties, t);
					n_curve++;
				end else begin
					pump = held_pump;
					fan  = held_fan;
					n_held++;
				end
			end
		endcase
		pf   = int'(limits[7:0]);
		ff   = int'(limits[15:8]);
		pmax = int'(limits[23:16]);
		if (pmax > 100) pmax = 100;
		// floor first, then ceiling: floor above max yields max
		if (pump < pf) pump = pf;
		if (pump > pmax) pump = pmax;
		if (fan < ff) fan = ff;
		if (fan > 100) fan = 100;
		held_pump = pump & 8'h7F;
		held_fan  = fan & 8'h7F;
		cmd.pump = ccdc_pkg::duty_t'(held_pump);
		cmd.fan  = ccdc_pkg::duty_t'(held_fan);
		cmd.sent = 1'b1;
		return cmd;
	endfunction

	// Sample driver: predicts on every accepted transaction.
	always @(posedge clk) begin
		if (!arst_n) begin
			smp.valid       <= 1'b0;
			smp.temp_tenths <= '0;
			smp.temp_ok     <= 1'b0;
			gap_left = 0;
		end else begin
			if (smp.valid && smp.ready)
				expected_cmds.insert(expected_cmds.size(),
					next_duty_command(smp.temp_tenths, smp.temp_ok));
			if (!smp.valid || smp.ready) begin
				if (gap_left > 0 && !steady) begin
					gap_left--;
					smp.valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					drv_sample = pending_samples.pop_front();
					smp.temp_tenths <= drv_sample.temp;
					smp.temp_ok     <= drv_sample.ok;
					smp.valid       <= 1'b1;
					gap_left = ($urandom_range(0, 2) == 0) ? gap_len() : 0;
				end else begin
					smp.valid <= 1'b0;
				end
			end
		end
	end

	task automatic report_mismatch(string what, int want, int got);
		errors++;
		if (errors <= REPORT_MAX)
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
	endtask

	// Result monitor with random back-pressure.
	always @(posedge clk) begin
		duty_cmd_t want;
		if (!arst_n) begin
			res.ready <= 1'b0;
			stall_left = 0;
		end else begin
			if (res.valid && res.ready) begin
				checked++;
				if (expected_cmds.size() == 0) begin
					errors++;
					if (errors <= REPORT_MAX)
						$display("%0t: unexpected result: expected none, actual %0d/%0d/%0b",
							$time, res.pump_pct, res.fan_pct, res.command_sent);
				end else begin
					want = expected_cmds.pop_front();
					if (res.pump_pct !== want.pump)
						report_mismatch("pump_pct", int'(want.pump), int'(res.pump_pct));
					if (res.fan_pct !== want.fan)
						report_mismatch("fan_pct", int'(want.fan), int'(res.fan_pct));
					if (res.command_sent !== want.sent)
						report_mismatch("command_sent", int'(want.sent),
							int'(res.command_sent));
				end
			end
			if (steady) begin
				res.ready <= 1'b1;
			end else if (stall_left > 0) begin
				stall_left--;
				res.ready <= 1'b0;
			end else begin
				stall_left = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
				res.ready <= (stall_left == 0);
			end
		end
	end

	// Register write; the shadow follows at once since nothing is in flight.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_idx   <= idx;
		cfg_wdata <= val;
		case (idx)
			ccdc_pkg::REG_MODE:        cur_mode    = val[2:0];
			ccdc_pkg::REG_PUMP_TEMPS:  pump_temps  = val;
			ccdc_pkg::REG_PUMP_DUTIES: pump_duties = val[31:0];
			ccdc_pkg::REG_FAN_TEMPS:   fan_temps   = val;
			ccdc_pkg::REG_FAN_DUTIES:  fan_duties  = val[31:0];
			ccdc_pkg::REG_PRESETS:     presets     = val;
			ccdc_pkg::REG_LIMITS:      limits      = val[23:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send(input int temp, input logic ok);
		sample_t s;
		s.temp = temp[ccdc_pkg::TEMP_W-1:0];
		s.ok   = ok;
		pending_samples.insert(pending_samples.size(), s);
	endtask

	// wait for every transaction and result, then let the pipeline drain
	task automatic settle();
		while (pending_samples.size() > 0 || smp.valid || expected_cmds.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		phases++;
	endtask

	task automatic make_curve(output logic [63:0] temps, output logic [31:0] duties);
		int unsigned kind, pt;
		kind = $urandom_range(0, 99);
		temps = '0;
		if (kind < 70) begin
			// ascending, with the odd flat segment
			pt = $urandom_range(0, 600);
			for (int k = 0; k < 4; k++) begin
				temps[16*k +: 16] = pt[15:0];
				pt += ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 300);
			end
		end else if (kind < 78) begin
			temps = '1;
		end else if (kind < 83) begin
			temps = '0;
		end else begin
			temps = {$urandom, $urandom};
		end
		for (int k = 0; k < 4; k++)
			duties[8*k +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
				: 8'($urandom_range(0, 100));
		if ($urandom_range(0, 19) == 0) duties = '1;
		if ($urandom_range(0, 19) == 0) duties = '0;
	endtask

	task automatic shuffle_settings();
		logic [63:0] temps;
		logic [31:0] duties;
		logic [23:0] lim;
		logic [2:0]  mode;
		make_curve(temps, duties);
		write_reg(ccdc_pkg::REG_PUMP_TEMPS, temps);
		write_reg(ccdc_pkg::REG_PUMP_DUTIES, {32'd0, duties});
		make_curve(temps, duties);
		write_reg(ccdc_pkg::REG_FAN_TEMPS, temps);
		write_reg(ccdc_pkg::REG_FAN_DUTIES, {32'd0, duties});
		case ($urandom_range(0, 9))
			0:       write_reg(ccdc_pkg::REG_PRESETS, '1);
			1:       write_reg(ccdc_pkg::REG_PRESETS, '0);
			default: write_reg(ccdc_pkg::REG_PRESETS, {$urandom, $urandom});
		endcase
		case ($urandom_range(0, 9))
			0:       lim = '1;
			1:       lim = '0;
			2, 3:    lim = 24'($urandom);
			default: lim = {8'($urandom_range(50, 100)), 8'($urandom_range(0, 40)),
				8'($urandom_range(0, 40))};
		endcase
		write_reg(ccdc_pkg::REG_LIMITS, {40'd0, lim});
		// auto most of the time so the curves get exercised
		mode = ($urandom_range(0, 99) < 55) ? ccdc_pkg::MODE_AUTO : 3'($urandom_range(1, 7));
		write_reg(ccdc_pkg::REG_MODE, {61'd0, mode});
		if ($urandom_range(0, 9) == 0)
			write_reg(REG_UNUSED, {$urandom, $urandom});
	endtask

	initial begin
		int          n, top, pt, r;
		logic [15:0] tmp;

		errors = 0; cycles = 0; checked = 0; phases = 0;
		n_curve = 0; n_held = 0; n_preset = 0; n_off = 0;
		steady = 1'b0;
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_idx   = ccdc_pkg::REG_MODE;
		cfg_wdata = '0;
		smp.valid       = 1'b0;
		smp.temp_tenths = '0;
		smp.temp_ok     = 1'b0;
		res.ready       = 1'b0;

		cur_mode    = ccdc_pkg::MODE_AUTO;
		pump_temps  = ccdc_pkg::RST_PUMP_TEMPS;
		pump_duties = ccdc_pkg::RST_PUMP_DUTIES;
		fan_temps   = ccdc_pkg::RST_FAN_TEMPS;
		fan_duties  = ccdc_pkg::RST_FAN_DUTIES;
		presets     = ccdc_pkg::RST_PRESETS;
		limits      = ccdc_pkg::RST_LIMITS;
		held_pump   = 0;
		held_fan    = 0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset curves (500/530/560/580 tenths).
		send(350, 1'b0);        // invalid: zero held duties raised to the floors
		send(-1, 1'b1);         // negative: held
		send(-32768, 1'b1);
		send(0, 1'b1);          // below the first point
		send(200, 1'b1);
		send(250, 1'b1);        // below the first point as well
		send(300, 1'b1);
		send(401, 1'b1);
		send(580, 1'b1);
		send(32767, 1'b1);      // above the last point
		send(100, 1'b0);        // held from the last valid sample
		settle();

		// fixed modes, one sample each; performance presets above 100
		write_reg(ccdc_pkg::REG_PRESETS, 64'hFFFF_6450_3C28_050A);
		write_reg(ccdc_pkg::REG_MODE, {61'd0, ccdc_pkg::MODE_SILENT});
		send(-5, 1'b0);
		settle();
		write_reg(ccdc_pkg::REG_MODE, {61'd0, ccdc_pkg::MODE_QUIET});
		send(32767, 1'b1);
		settle();
		write_reg(ccdc_pkg::REG_MODE, {61'd0, ccdc_pkg::MODE_BALANCED});
		send(0, 1'b1);
		settle();
		write_reg(ccdc_pkg::REG_MODE, {61'd0, ccdc_pkg::MODE_PERFORMANCE});
		send(-32768, 1'b0);
		settle();
		write_reg(ccdc_pkg::REG_MODE, {61'd0, ccdc_pkg::MODE_DISABLED});
		send(300, 1'b1);        // no command, held duties untouched
		settle();
		write_reg(ccdc_pkg::REG_MODE, {61'd0, MODE_SPARE_6});
		send(300, 1'b0);        // behaves as auto: held
		settle();

		// flat middle segment, floor above max, max above 100, unused index
		write_reg(ccdc_pkg::REG_MODE, {61'd0, MODE_SPARE_7});
		write_reg(ccdc_pkg::REG_PUMP_TEMPS, {16'd600, 16'd300, 16'd300, 16'd100});
		write_reg(ccdc_pkg::REG_LIMITS, {40'd0, 8'd30, 8'd90, 8'd60});
		send(300, 1'b1);
		send(450, 1'b1);
		settle();
		write_reg(ccdc_pkg::REG_LIMITS, {40'd0, 8'd200, 8'd0, 8'd0});
		write_reg(REG_UNUSED, '1);
		send(32767, 1'b1);
		settle();

		// Random phases: fresh settings each phase, samples mostly inside the curves.
		n = 0;
		while (n < RANDOM_ITEMS) begin
			shuffle_settings();
			steady = ($urandom_range(0, 99) < 15);
			top = 0;
			for (int k = 0; k < 4; k++) begin
				if (int'(pump_temps[16*k +: 16]) > top) top = int'(pump_temps[16*k +: 16]);
				if (int'(fan_temps[16*k +: 16]) > top) top = int'(fan_temps[16*k +: 16]);
			end
			top = (top + 50 > 32767) ? 32767 : top + 50;
			repeat ($urandom_range(20, 80)) begin
				r = $urandom_range(0, 99);
				if (r < 70) begin
					tmp = 16'($urandom_range(0, top));
				end else if (r < 80) begin
					// right on a breakpoint
					pt  = $urandom_range(0, 3);
					tmp = $urandom_range(0, 1) ? pump_temps[16*pt +: 16]
						: fan_temps[16*pt +: 16];
				end else if (r < 90) begin
					tmp = 16'($urandom);
				end else begin
					tmp = 16'($urandom_range(32768, 65535));
				end
				send(int'(signed'(tmp)), ($urandom_range(0, 9) != 0));
				n++;
			end
			settle();
			steady = 1'b0;
		end

		$display("Checked %0d results over %0d register settings.", checked, phases);
		$display("Auto curve %0d, held %0d, preset %0d, disabled %0d.",
			n_curve, n_held, n_preset, n_off);
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d mismatches", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/ccdc_pkg.sv
rtl/core/ccdc_if.sv
rtl/core/ccdc_curve_eval.sv
rtl/core/cooling_curve_duty_controller_unit.sv
tb/cooling_curve_duty_controller_unit_test.sv
